>>> hdl/brq_pkg.sv
// Package of the bounded request queue: widths, codes, payload and control types.
package brq_pkg;

   // Queue storage
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int OP_W        = 2;
   localparam int CONN_W      = 16;
   localparam int INFO_W      = 32;
   localparam int ENTRY_W     = CONN_W + INFO_W;
   localparam int KIND_W      = 3;
   localparam int OUT_CNT_W   = 5;

   // Configuration port
   localparam int CAP_W       = 5;
   localparam int POLICY_W    = 2;
   localparam int SEED_W      = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED     = 2'd2;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [SEED_W-1:0] SEED_RESET     = 16'd1;
   localparam logic [SEED_W-1:0] LFSR_TAPS      = 16'hB400;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;

   // Overload policies
   localparam logic [POLICY_W-1:0] POLICY_BLOCK    = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_DROP_NEW = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_DROP_OLD = 2'd2;
   localparam logic [POLICY_W-1:0] POLICY_RANDOM   = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPTED    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NEW_DROPPED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OLD_EVICTED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RETRY_FULL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEQUEUED    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EMPTY       = 3'd5;
   localparam logic [KIND_W-1:0] KIND_COMPLETED   = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [CONN_W-1:0] conn_id;
      logic [INFO_W-1:0] request_info;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0]    result_kind;
      logic [CONN_W-1:0]    out_conn_id;
      logic [INFO_W-1:0]    out_request_info;
      logic [OUT_CNT_W-1:0] waiting_count;
      logic [OUT_CNT_W-1:0] in_flight_count;
      logic                 last_result;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_ITEM,
      SRC_RDATA
   } src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DEQ_EMIT,
      ST_OLD_EMIT,
      ST_RAND_PICK,
      ST_RAND_EMIT,
      ST_COMP_RD,
      ST_COMP_WR,
      ST_INSERT
   } ctrl_state_type;

   typedef struct packed {
      logic              load_item;
      logic              ins_new;
      logic              rd_oldest;
      logic              inflight_inc;
      logic              inflight_dec;
      logic              rand_init;
      logic              rand_step;
      logic              comp_skip;
      logic              comp_read;
      logic              comp_write;
      logic              emit;
      logic [KIND_W-1:0] emit_kind;
      src_type           emit_src;
      logic              emit_last;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                full;
      logic [POLICY_W-1:0] policy;
      logic                wait_zero;
      logic                pick_hit;
      logic                evict_done;
      logic                comp_done;
      logic                comp_marked;
      logic                out_free;
   } stat_type;

endpackage

>>> hdl/brq_ctrl.sv
// Controller state machine of the bounded request queue.
module brq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  brq_pkg::stat_type  stat,
   output brq_pkg::cmd_type   cmd,
   output logic               req_stall
);

   brq_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brq_pkg::ST_IDLE: begin
            if (req_valid) state_in = brq_pkg::ST_EXEC;
         end
         brq_pkg::ST_EXEC: begin
            if (stat.out_free) begin
               state_in = brq_pkg::ST_IDLE;
               case (stat.op)
                  brq_pkg::OP_ENQUEUE: begin
                     if (stat.full && !stat.wait_zero) begin
                        if (stat.policy == brq_pkg::POLICY_DROP_OLD) begin
                           state_in = brq_pkg::ST_OLD_EMIT;
                        end else if (stat.policy == brq_pkg::POLICY_RANDOM) begin
                           state_in = brq_pkg::ST_RAND_PICK;
                        end
                     end
                  end
                  brq_pkg::OP_DEQUEUE: begin
                     if (!stat.wait_zero) state_in = brq_pkg::ST_DEQ_EMIT;
                  end
                  default: state_in = brq_pkg::ST_IDLE;
               endcase
            end
         end
         brq_pkg::ST_DEQ_EMIT: begin
            if (stat.out_free) state_in = brq_pkg::ST_IDLE;
         end
         brq_pkg::ST_OLD_EMIT: begin
            if (stat.out_free) state_in = brq_pkg::ST_INSERT;
         end
         brq_pkg::ST_RAND_PICK: begin
            if (stat.pick_hit) state_in = brq_pkg::ST_RAND_EMIT;
         end
         brq_pkg::ST_RAND_EMIT: begin
            if (stat.out_free) begin
               state_in = stat.evict_done ? brq_pkg::ST_COMP_RD : brq_pkg::ST_RAND_PICK;
            end
         end
         brq_pkg::ST_COMP_RD: begin
            if (stat.comp_done) begin
               state_in = brq_pkg::ST_INSERT;
            end else if (!stat.comp_marked) begin
               state_in = brq_pkg::ST_COMP_WR;
            end
         end
         brq_pkg::ST_COMP_WR: state_in = brq_pkg::ST_COMP_RD;
         brq_pkg::ST_INSERT: begin
            if (stat.out_free) state_in = brq_pkg::ST_IDLE;
         end
         default: state_in = brq_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd           = '0;
      cmd.emit_kind = brq_pkg::KIND_ACCEPTED;
      cmd.emit_src  = brq_pkg::SRC_ZERO;
      req_stall     = (state_ff != brq_pkg::ST_IDLE);
      case (state_ff)
         brq_pkg::ST_IDLE: begin
            cmd.load_item = req_valid;
         end
         brq_pkg::ST_EXEC: begin
            if (stat.out_free) begin
               case (stat.op)
                  brq_pkg::OP_ENQUEUE: begin
                     if (!stat.full) begin
                        cmd.ins_new   = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                     end else if (stat.policy == brq_pkg::POLICY_BLOCK) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = brq_pkg::KIND_RETRY_FULL;
                        cmd.emit_last = 1'b1;
                     end else if (stat.policy == brq_pkg::POLICY_DROP_NEW ||
                                  stat.wait_zero) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = brq_pkg::KIND_NEW_DROPPED;
                        cmd.emit_src  = brq_pkg::SRC_ITEM;
                        cmd.emit_last = 1'b1;
                     end else if (stat.policy == brq_pkg::POLICY_DROP_OLD) begin
                        cmd.rd_oldest = 1'b1;
                     end else begin
                        cmd.rand_init = 1'b1;
                     end
                  end
                  brq_pkg::OP_DEQUEUE: begin
                     if (stat.wait_zero) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = brq_pkg::KIND_EMPTY;
                        cmd.emit_last = 1'b1;
                     end else begin
                        cmd.rd_oldest    = 1'b1;
                        cmd.inflight_inc = 1'b1;
                     end
                  end
                  brq_pkg::OP_COMPLETE: begin
                     cmd.inflight_dec = 1'b1;
                     cmd.emit         = 1'b1;
                     cmd.emit_kind    = brq_pkg::KIND_COMPLETED;
                     cmd.emit_last    = 1'b1;
                  end
                  default: cmd.emit = 1'b0;
               endcase
            end
         end
         brq_pkg::ST_DEQ_EMIT: begin
            cmd.emit      = stat.out_free;
            cmd.emit_kind = brq_pkg::KIND_DEQUEUED;
            cmd.emit_src  = brq_pkg::SRC_RDATA;
            cmd.emit_last = 1'b1;
         end
         brq_pkg::ST_OLD_EMIT, brq_pkg::ST_RAND_EMIT: begin
            cmd.emit      = stat.out_free;
            cmd.emit_kind = brq_pkg::KIND_OLD_EVICTED;
            cmd.emit_src  = brq_pkg::SRC_RDATA;
         end
         brq_pkg::ST_RAND_PICK: begin
            cmd.rand_step = 1'b1;
         end
         brq_pkg::ST_COMP_RD: begin
            if (!stat.comp_done) begin
               cmd.comp_skip = stat.comp_marked;
               cmd.comp_read = !stat.comp_marked;
            end
         end
         brq_pkg::ST_COMP_WR: begin
            cmd.comp_write = 1'b1;
         end
         brq_pkg::ST_INSERT: begin
            cmd.ins_new   = stat.out_free;
            cmd.emit      = stat.out_free;
            cmd.emit_last = 1'b1;
         end
         default: cmd.emit = 1'b0;
      endcase
   end

endmodule

>>> hdl/brq_datapath.sv
// Datapath of the bounded request queue: entry memory, counters, victim LFSR, result register.
module brq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  brq_pkg::req_payload_type          req_payload,
   input  logic                              csr_write_en,
   input  logic [brq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  brq_pkg::cmd_type                  cmd,
   output brq_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output brq_pkg::rsp_payload_type          rsp_payload
);

   localparam int IDX_W = brq_pkg::IDX_W;
   localparam int CNT_W = brq_pkg::CNT_W;
   localparam int DEPTH = brq_pkg::QUEUE_DEPTH;
   localparam int CMP_W = ((CNT_W + 1) > brq_pkg::CAP_W) ? (CNT_W + 1) : brq_pkg::CAP_W;

   // Physical slot of a logical position counted from the newest entry
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] off);
      logic [IDX_W:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= (IDX_W + 1)'(DEPTH)) s = s - (IDX_W + 1)'(DEPTH);
      return s[IDX_W-1:0];
   endfunction

   logic [brq_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [brq_pkg::ENTRY_W-1:0] rd_data_ff;

   brq_pkg::req_payload_type  item_ff;
   brq_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]          waiting_ff, waiting_in;
   logic [CNT_W-1:0]          in_flight_ff, in_flight_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [brq_pkg::SEED_W-1:0] lfsr_ff, lfsr_in;
   logic [DEPTH-1:0]          marks_ff, marks_in;
   logic [brq_pkg::CAP_W-1:0] capacity_ff;
   logic [brq_pkg::POLICY_W-1:0] policy_ff;

   logic [CNT_W-1:0]          n_ff, cnt_ff, e_ff, i_ff, j_ff;
   logic [IDX_W-1:0]          mask_ff;

   logic [IDX_W-1:0]          head_dec, oldest_off, idx, mask_in;
   logic [CNT_W-1:0]          wait_m1;
   logic [CNT_W:0]            half_up;
   logic [CMP_W-1:0]          sum_cmp, cap_cmp;
   logic                      hit;
   logic                      mem_we, mem_re;
   logic [IDX_W-1:0]          waddr, raddr;
   logic [brq_pkg::ENTRY_W-1:0] wdata;
   logic [brq_pkg::ENTRY_W-1:0] emit_entry;

   assign head_dec   = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign wait_m1    = waiting_ff - CNT_W'(1);
   assign oldest_off = wait_m1[IDX_W-1:0];
   assign half_up    = ({1'b0, waiting_ff} + (CNT_W + 1)'(1)) >> 1;

   // Full test against the capacity clamped to the depth
   assign sum_cmp = CMP_W'(waiting_ff) + CMP_W'(in_flight_ff);
   assign cap_cmp = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(capacity_ff);

   // Victim index mask: n-1 smeared down to the next power of two minus one
   always_comb begin
      mask_in = oldest_off;
      for (int k = 0; k < IDX_W; k++) begin
         mask_in = mask_in | (mask_in >> 1);
      end
   end

   // LFSR seed load, advance and next value
   always_comb begin
      lfsr_in = lfsr_ff;
      if (csr_write_en && csr_index == brq_pkg::CSR_SEED) begin
         lfsr_in = (csr_wdata == '0) ? brq_pkg::SEED_RESET : csr_wdata;
      end else if (cmd.rand_step) begin
         lfsr_in = {1'b0, lfsr_ff[brq_pkg::SEED_W-1:1]} ^
                   (lfsr_ff[0] ? brq_pkg::LFSR_TAPS : '0);
      end
   end

   assign idx = lfsr_in[IDX_W-1:0] & mask_ff;
   assign hit = cmd.rand_step && (CNT_W'(idx) < n_ff) && !marks_ff[idx];

   // Counters and eviction bookkeeping
   always_comb begin
      waiting_in   = waiting_ff;
      in_flight_in = in_flight_ff;
      head_in      = head_ff;
      marks_in     = marks_ff;
      if (cmd.ins_new) begin
         waiting_in = waiting_ff + CNT_W'(1);
         head_in    = head_dec;
      end
      if (cmd.rd_oldest || hit) waiting_in = wait_m1;
      if (cmd.inflight_inc) in_flight_in = in_flight_ff + CNT_W'(1);
      if (cmd.inflight_dec && in_flight_ff != '0) in_flight_in = in_flight_ff - CNT_W'(1);
      if (cmd.rand_init) marks_in = '0;
      if (hit) marks_in = marks_ff | (DEPTH'(1) << idx);
   end

   // Memory port selection
   always_comb begin
      mem_we = cmd.ins_new || cmd.comp_write;
      waddr  = cmd.ins_new ? head_dec : phys(head_ff, j_ff[IDX_W-1:0]);
      wdata  = cmd.ins_new ? {item_ff.conn_id, item_ff.request_info} : rd_data_ff;
      mem_re = cmd.rd_oldest || hit || cmd.comp_read;
      if (cmd.rd_oldest) begin
         raddr = phys(head_ff, oldest_off);
      end else if (cmd.comp_read) begin
         raddr = phys(head_ff, i_ff[IDX_W-1:0]);
      end else begin
         raddr = phys(head_ff, idx);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (mem_re) rd_data_ff <= mem[raddr];
   end

   // Result register
   always_comb begin
      case (cmd.emit_src)
         brq_pkg::SRC_ITEM:  emit_entry = {item_ff.conn_id, item_ff.request_info};
         brq_pkg::SRC_RDATA: emit_entry = rd_data_ff;
         default:            emit_entry = '0;
      endcase
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in                    = 1'b1;
         rsp_payload_in.result_kind      = cmd.emit_kind;
         rsp_payload_in.out_conn_id      = emit_entry[brq_pkg::ENTRY_W-1:brq_pkg::INFO_W];
         rsp_payload_in.out_request_info = emit_entry[brq_pkg::INFO_W-1:0];
         rsp_payload_in.waiting_count    = brq_pkg::OUT_CNT_W'(waiting_in);
         rsp_payload_in.in_flight_count  = brq_pkg::OUT_CNT_W'(in_flight_in);
         rsp_payload_in.last_result      = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= '0;
         in_flight_ff <= '0;
         head_ff      <= '0;
         lfsr_ff      <= brq_pkg::SEED_RESET;
         marks_ff     <= '0;
         capacity_ff  <= brq_pkg::CAPACITY_RESET;
         policy_ff    <= brq_pkg::POLICY_BLOCK;
         rsp_valid_ff <= 1'b0;
      end else begin
         waiting_ff   <= waiting_in;
         in_flight_ff <= in_flight_in;
         head_ff      <= head_in;
         lfsr_ff      <= lfsr_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en && csr_index == brq_pkg::CSR_CAPACITY) begin
            capacity_ff <= csr_wdata[brq_pkg::CAP_W-1:0];
         end
         if (csr_write_en && csr_index == brq_pkg::CSR_POLICY) begin
            policy_ff <= csr_wdata[brq_pkg::POLICY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (cmd.load_item) item_ff <= req_payload;
      if (cmd.rand_init) begin
         n_ff    <= waiting_ff;
         cnt_ff  <= half_up[CNT_W-1:0];
         mask_ff <= mask_in;
         e_ff    <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
      end
      if (hit) e_ff <= e_ff + CNT_W'(1);
      if (cmd.comp_skip) i_ff <= i_ff + CNT_W'(1);
      if (cmd.comp_write) begin
         i_ff <= i_ff + CNT_W'(1);
         j_ff <= j_ff + CNT_W'(1);
      end
   end

   assign stat.op          = item_ff.operation;
   assign stat.full        = (sum_cmp >= cap_cmp);
   assign stat.policy      = policy_ff;
   assign stat.wait_zero   = (waiting_ff == '0);
   assign stat.pick_hit    = hit;
   assign stat.evict_done  = (e_ff == cnt_ff);
   assign stat.comp_done   = (i_ff == n_ff);
   assign stat.comp_marked = marks_ff[i_ff[IDX_W-1:0]];
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hdl/bounded_request_queue_overload_drop.sv
// Top level of the bounded request queue with overload drop policies.
// One transaction at a time: accept, then decide in the execute state; accepted when not full,
// retry, dropped, empty and completed results emit from it, dequeue and drop-oldest read first, then emit.
// Random eviction walks the victim LFSR one draw per cycle while picking, redrawing rejected
// indices, emits each victim on a free output, then compacts survivors by a read and a write
// per kept entry. Synchronous reset clears the counters, marks and result valid, loads capacity
// 16, policy block and LFSR seed 1; the entry memory is not cleared and needs no clearing pass.
module bounded_request_queue_overload_drop (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  brq_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output brq_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_write_en,
   input  logic [brq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   brq_pkg::cmd_type  cmd;
   brq_pkg::stat_type stat;

   // Sequence each transaction: decide, read, emit, evict, compact, insert
   brq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // Hold entries, counters, LFSR and the result register
   brq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

>>> tb/tb_bounded_request_queue_overload_drop.sv
// Self-checking testbench of the bounded request queue: overload policies, eviction, stalls.
module tb_bounded_request_queue_overload_drop;
   timeunit 1ns;
   timeprecision 1ps;
   import brq_pkg::*;

   // Operation code and register index that the block leaves unused
   localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int HOLDOFF_CYCLES = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES  = 50;    // quiet time after the last result
   localparam int IDLE_LIMIT     = 5000;  // cycles with no transaction before giving up
   localparam int PHASE_ITEMS    = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the queue: index 0 holds the newest entry, the oldest sits at
   // shadow_waiting-1.
   logic [ENTRY_W-1:0]  shadow_store [QUEUE_DEPTH];
   int unsigned         shadow_waiting;
   int unsigned         shadow_in_flight;
   logic [SEED_W-1:0]   shadow_lfsr;
   logic [CAP_W-1:0]    set_capacity;
   logic [POLICY_W-1:0] set_policy;

   // Results still owed by the block, oldest first
   rsp_payload_type outcomes_due [$];
   int unsigned     mismatch_count;
   int unsigned     idle_cycles;

   // Hold-off handshake between the test sequence and the receiver process
   int unsigned holdoff_requests;
   int unsigned holdoffs_served;

   // Sender burst state
   int unsigned burst_left;
   bit          sender_gaps;

   bounded_request_queue_overload_drop u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Build one result from the shadow counters as they stand right now.
   function automatic rsp_payload_type make_outcome(input logic [KIND_W-1:0]  kind,
                                                    input logic [ENTRY_W-1:0] entry);
      rsp_payload_type r;
      r.result_kind      = kind;
      r.out_conn_id      = entry[ENTRY_W-1:INFO_W];
      r.out_request_info = entry[INFO_W-1:0];
      r.waiting_count    = OUT_CNT_W'(shadow_waiting);
      r.in_flight_count  = OUT_CNT_W'(shadow_in_flight);
      r.last_result      = 1'b0;
      return r;
   endfunction

   // Push the new request in at the young end; a full store takes nothing.
   task automatic insert_entry(input logic [ENTRY_W-1:0] entry);
      if (shadow_waiting < QUEUE_DEPTH) begin
         for (int i = shadow_waiting; i > 0; i--)
            shadow_store[i] = shadow_store[i-1];
         shadow_store[0] = entry;
         shadow_waiting++;
      end
   endtask

   // Work out every result that one accepted transaction causes and queue them up.
   task automatic predict_queue_op(input req_payload_type item);
      rsp_payload_type        batch [$];
      rsp_payload_type        one;
      logic [ENTRY_W-1:0]     entry;
      logic [QUEUE_DEPTH-1:0] marks;
      int unsigned            limit;
      int unsigned            n;
      int unsigned            cnt;
      int unsigned            mask;
      int unsigned            idx;
      int unsigned            j;
      entry = {item.conn_id, item.request_info};
      limit = (set_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : set_capacity;
      if (item.operation == OP_ENQUEUE) begin
         if (shadow_waiting + shadow_in_flight < limit) begin
            insert_entry(entry);
            batch.push_back(make_outcome(KIND_ACCEPTED, '0));
         end else if (set_policy == POLICY_BLOCK) begin
            batch.push_back(make_outcome(KIND_RETRY_FULL, '0));
         end else if (set_policy == POLICY_DROP_NEW || shadow_waiting == 0) begin
            // drop-new policy, or nothing waiting to evict: the newcomer goes instead
            batch.push_back(make_outcome(KIND_NEW_DROPPED, entry));
         end else begin
            if (set_policy == POLICY_DROP_OLD) begin
               shadow_waiting--;
               batch.push_back(make_outcome(KIND_OLD_EVICTED, shadow_store[shadow_waiting]));
            end else begin
               // Evict half the waiting entries (rounded up), victims drawn from the
               // LFSR and redrawn when out of range or already taken.
               n    = shadow_waiting;
               cnt  = (n + 1) / 2;
               mask = 1;
               while (mask < n)
                  mask = mask << 1;
               mask  = mask - 1;
               marks = '0;
               for (int e = 0; e < cnt; e++) begin
                  do begin
                     shadow_lfsr = shadow_lfsr[0] ? ((shadow_lfsr >> 1) ^ LFSR_TAPS)
                                                  : (shadow_lfsr >> 1);
                     idx = shadow_lfsr & mask;
                  end while (idx >= n || marks[idx]);
                  marks[idx]     = 1'b1;
                  shadow_waiting = n - (e + 1);
                  batch.push_back(make_outcome(KIND_OLD_EVICTED, shadow_store[idx]));
               end
               // compact the survivors, keeping their order
               j = 0;
               for (int i = 0; i < n; i++) begin
                  if (!marks[i]) begin
                     shadow_store[j] = shadow_store[i];
                     j++;
                  end
               end
               shadow_waiting = n - cnt;
            end
            insert_entry(entry);
            batch.push_back(make_outcome(KIND_ACCEPTED, '0));
         end
      end else if (item.operation == OP_DEQUEUE) begin
         if (shadow_waiting == 0) begin
            batch.push_back(make_outcome(KIND_EMPTY, '0));
         end else begin
            shadow_waiting--;
            shadow_in_flight++;
            batch.push_back(make_outcome(KIND_DEQUEUED, shadow_store[shadow_waiting]));
         end
      end else if (item.operation == OP_COMPLETE) begin
         if (shadow_in_flight > 0)
            shadow_in_flight--;
         batch.push_back(make_outcome(KIND_COMPLETED, '0));
      end
      // the unused operation leaves the batch empty
      foreach (batch[k]) begin
         one             = batch[k];
         one.last_result = (k == batch.size() - 1);
         outcomes_due.push_back(one);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_payload_type make_item(input logic [OP_W-1:0]   op,
                                                 input logic [CONN_W-1:0] conn,
                                                 input logic [INFO_W-1:0] info);
      req_payload_type item;
      item.operation    = op;
      item.conn_id      = conn;
      item.request_info = info;
      return item;
   endfunction

   // Random transaction with a given share of enqueues; the rest splits between
   // dequeue and complete, with a trickle of the unused code.
   function automatic req_payload_type random_item(input int unsigned enq_pct);
      int unsigned     roll;
      logic [OP_W-1:0] op;
      roll = $urandom_range(99, 0);
      if (roll < enq_pct)
         op = OP_ENQUEUE;
      else if (roll < enq_pct + (100 - enq_pct) / 2)
         op = OP_DEQUEUE;
      else if (roll < 96)
         op = OP_COMPLETE;
      else
         op = OP_UNUSED;
      return make_item(op, CONN_W'($urandom), INFO_W'($urandom));
   endfunction

   // Offer a transaction and hold it until the block takes it. Called in step with the
   // clock; returns as soon as the block has taken it, with valid still high.
   task automatic send_item(input req_payload_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_queue_op(item);
   endtask

   // Send in bursts of random length, dropping valid for random gaps between them.
   task automatic offer_item(input req_payload_type item);
      int unsigned gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(6, 0);
         if ($urandom_range(9, 0) == 0)
            gap = $urandom_range(30, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      if (burst_left > 0)
         burst_left--;
      send_item(item);
   endtask

   // Stop sending, wait for every owed result, then let the block settle
   // (an unused operation may still be in progress with nothing owed).
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers the write enable after the last one.
   task automatic write_csr(input logic [CSR_IDX_W-1:0]  index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      case (index)
         CSR_CAPACITY: set_capacity = data[CAP_W-1:0];
         CSR_POLICY:   set_policy   = data[POLICY_W-1:0];
         CSR_SEED:     shadow_lfsr  = (data[SEED_W-1:0] == '0) ? SEED_W'(1) : data[SEED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] cap_word,
                                 input logic [POLICY_W-1:0]   policy,
                                 input bit                    reseed,
                                 input logic [SEED_W-1:0]     seed);
      wait_until_idle();
      write_csr(CSR_CAPACITY, cap_word);
      write_csr(CSR_POLICY, CSR_DATA_W'(policy));
      if (reseed)
         write_csr(CSR_SEED, CSR_DATA_W'(seed));
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: empty dequeue, complete with nothing in flight, extreme
   // payloads, the unused operation and the unused register index.
   task automatic test_reset_defaults();
      offer_item(make_item(OP_DEQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_COMPLETE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_ENQUEUE, '0, '0));
      offer_item(make_item(OP_ENQUEUE, '1, '1));
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_DEQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_UNUSED, CONN_W'($urandom), INFO_W'($urandom)));
      wait_until_idle();
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_write_en <= 1'b0;
   endtask

   // Block policy: retry on full, in-flight requests count against capacity,
   // capacity zero is always full, capacity above the depth acts as the depth.
   task automatic test_block_policy();
      apply_settings(CSR_DATA_W'(2), POLICY_BLOCK, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_COMPLETE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_DEQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      apply_settings(CSR_DATA_W'(0), POLICY_BLOCK, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      apply_settings(CSR_DATA_W'(31), POLICY_BLOCK, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
   endtask

   // Drop-new and drop-oldest on a full queue, then both eviction policies on a
   // full queue with nothing waiting, where the newcomer is dropped.
   task automatic test_drop_policies();
      apply_settings(CSR_DATA_W'(2), POLICY_DROP_NEW, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      apply_settings(CSR_DATA_W'(2), POLICY_DROP_OLD, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      repeat (3) offer_item(make_item(OP_DEQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      apply_settings(CSR_DATA_W'(0), POLICY_DROP_OLD, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      apply_settings(CSR_DATA_W'(0), POLICY_RANDOM, 1'b0, '0);
      offer_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
   endtask

   // Hold the receiver off while the sender keeps offering enqueues back to back:
   // the block backs up and stalls its input. The queue fills to the full depth, so
   // the first random eviction takes the largest batch. Seed zero acts as one.
   task automatic test_holdoff_random_eviction();
      int unsigned busy;
      apply_settings(CSR_DATA_W'(16), POLICY_RANDOM, 1'b1, '0);
      busy = shadow_in_flight;
      repeat (busy) offer_item(make_item(OP_COMPLETE, CONN_W'($urandom), INFO_W'($urandom)));
      wait_until_idle();
      sender_gaps = 1'b0;
      holdoff_requests++;
      repeat (24) send_item(make_item(OP_ENQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
      sender_gaps = 1'b1;
      repeat (8) offer_item(make_item(OP_DEQUEUE, CONN_W'($urandom), INFO_W'($urandom)));
   endtask

   // Random traffic over several settings, extremes first, then random ones.
   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] cap_word;
      logic [CAP_W-1:0]      cap;
      logic [POLICY_W-1:0]   policy;
      logic [SEED_W-1:0]     seed;
      bit                    reseed;
      int unsigned           enq_pct;
      for (int p = 0; p < 8; p++) begin
         reseed  = 1'b1;
         seed    = SEED_W'($urandom);
         enq_pct = 50;
         case (p)
            0: begin
               cap     = CAP_W'(16);
               policy  = POLICY_RANDOM;
               seed    = '1;
               enq_pct = 65;
            end
            1: begin
               cap    = CAP_W'(1);
               policy = POLICY_BLOCK;
               reseed = 1'b0;
            end
            2: begin
               cap    = CAP_W'(0);
               policy = POLICY_DROP_OLD;
            end
            3: begin
               cap    = '1;
               policy = POLICY_DROP_NEW;
               reseed = 1'b0;
            end
            4: begin
               cap     = CAP_W'(16);
               policy  = POLICY_DROP_OLD;
               enq_pct = 65;
            end
            default: begin
               cap     = CAP_W'($urandom_range(16, 1));
               policy  = POLICY_W'($urandom_range(3, 0));
               enq_pct = $urandom_range(70, 45);
            end
         endcase
         // junk in the unused upper bits of the capacity word
         cap_word             = CSR_DATA_W'($urandom);
         cap_word[CAP_W-1:0]  = cap;
         apply_settings(cap_word, policy, reseed, seed);
         sender_gaps = ($urandom_range(3, 0) != 0);
         repeat (PHASE_ITEMS) offer_item(random_item(enq_pct));
      end
      sender_gaps = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_CAPACITY;
      csr_wdata        = '0;
      mismatch_count   = 0;
      holdoff_requests = 0;
      burst_left       = 0;
      sender_gaps      = 1'b1;
      shadow_waiting   = 0;
      shadow_in_flight = 0;
      shadow_lfsr      = SEED_RESET;
      set_capacity     = CAPACITY_RESET;
      set_policy       = POLICY_BLOCK;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_block_policy();
      test_drop_policies();
      test_holdoff_random_eviction();
      test_random_traffic();

      wait_until_idle();
      if (mismatch_count == 0)
         $display("PASS bounded_request_queue_overload_drop");
      else
         $display("FAIL bounded_request_queue_overload_drop");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: stall in segments of random style; serve hold-off requests by
   // stalling a fixed stretch counted here.
   // ------------------------------------------------------------------

   initial begin : receiver
      int unsigned seg_left;
      int unsigned hold_left;
      int unsigned style;
      rsp_stall       = 1'b0;
      holdoffs_served = 0;
      seg_left        = 0;
      hold_left       = 0;
      style           = 0;
      forever begin
         @(posedge clock);
         if (holdoffs_served != holdoff_requests) begin
            holdoffs_served++;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(80, 20);
               style    = $urandom_range(3, 0);
            end
            seg_left--;
            case (style)
               0:       rsp_stall <= 1'b0;                           // drain freely
               1:       rsp_stall <= ($urandom_range(3, 0) == 0);    // light
               2:       rsp_stall <= ($urandom_range(3, 0) != 0);    // heavy
               default: rsp_stall <= ~rsp_stall;                     // alternate
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Result check: compare each accepted result with the oldest owed result.
   // ------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [INFO_W-1:0] want,
                                input logic [INFO_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing owed, kind %0d conn %h info %h",
                     $time, rsp_payload.result_kind, rsp_payload.out_conn_id,
                     rsp_payload.out_request_info);
         end else begin
            want = outcomes_due.pop_front();
            compare_field("result_kind", INFO_W'(want.result_kind),
                          INFO_W'(rsp_payload.result_kind));
            compare_field("out_conn_id", INFO_W'(want.out_conn_id),
                          INFO_W'(rsp_payload.out_conn_id));
            compare_field("out_request_info", want.out_request_info,
                          rsp_payload.out_request_info);
            compare_field("waiting_count", INFO_W'(want.waiting_count),
                          INFO_W'(rsp_payload.waiting_count));
            compare_field("in_flight_count", INFO_W'(want.in_flight_count),
                          INFO_W'(rsp_payload.in_flight_count));
            compare_field("last_result", INFO_W'(want.last_result),
                          INFO_W'(rsp_payload.last_result));
         end
      end
   end

   // Watchdog: count cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results still owed",
                  $time, IDLE_LIMIT, outcomes_due.size());
         $display("FAIL bounded_request_queue_overload_drop");
         $finish;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
   end

endmodule

>>> bounded_request_queue_overload_drop.f
hdl/brq_pkg.sv
hdl/brq_ctrl.sv
hdl/brq_datapath.sv
hdl/bounded_request_queue_overload_drop.sv
tb/tb_bounded_request_queue_overload_drop.sv
